### rtl/hsv_pkg.sv
// hsv_pkg: shared widths, constants and the pipeline control struct
// for the hsv to rgb converter
// depends on: nothing
`default_nettype none

package hsv_pkg;

  localparam int STAGES = 6;

  localparam int HUE_W  = 16;
  localparam int UNIT_W = 13;
  localparam int DIST_W = 10;
  localparam int SD_W   = 23;
  localparam int W_W    = 22;
  localparam int VW_W   = 35;
  localparam int CH_W   = 8;

  localparam logic [UNIT_W-1:0] UNIT_ONE = 13'd4096;
  localparam logic [W_W-1:0]    W_FULL   = 22'd3932160;

  typedef struct packed {
    logic [STAGES-1:0] en;
    logic [STAGES-1:0] vld;
  } hsv_ctrl_t;

endpackage

`default_nettype wire

### rtl/hsv_ifs.sv
// hsv_in_if / hsv_out_if: valid-ready channels for hsv requests and rgb results
// depends on: nothing
`default_nettype none

interface hsv_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] hue;
  logic signed [15:0] saturation;
  logic signed [15:0] brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

### rtl/hsv_pipe_ctrl.sv
// hsv_pipe_ctrl: per-stage valid bits and load enables of the pipeline
// depends on: hsv_pkg
`default_nettype none

module hsv_pipe_ctrl
  import hsv_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      out_ready,
  output hsv_ctrl_t      ctrl
);

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] en;

  // a stage loads when it is empty or its successor moves on
  always_comb begin
    en[STAGES-1] = !vld[STAGES-1] || out_ready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  assign ctrl.en  = en;
  assign ctrl.vld = vld;

endmodule

`default_nettype wire

### rtl/hsv_hue_path.sv
// hsv_hue_path: stages one to three, clamps s and v, wraps the hue into one turn
// and picks each channel's weight distance; depends on: hsv_pkg
`default_nettype none

module hsv_hue_path
  import hsv_pkg::*;
(
  input  wire logic                    clk,
  input  wire hsv_ctrl_t               ctrl,
  input  wire logic signed [HUE_W-1:0] hue,
  input  wire logic signed [HUE_W-1:0] saturation,
  input  wire logic signed [HUE_W-1:0] brightness,
  output logic [UNIT_W-1:0]            s_out,
  output logic [UNIT_W-1:0]            v_out,
  output logic [DIST_W-1:0]            d_red,
  output logic [DIST_W-1:0]            d_green,
  output logic [DIST_W-1:0]            d_blue
);

  localparam logic [2:0] SEC_0 = 3'd0;
  localparam logic [2:0] SEC_1 = 3'd1;
  localparam logic [2:0] SEC_2 = 3'd2;
  localparam logic [2:0] SEC_3 = 3'd3;
  localparam logic [2:0] SEC_4 = 3'd4;
  localparam logic [2:0] SEC_5 = 3'd5;

  localparam logic [DIST_W-1:0] D_FULL = 10'd960;

  function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [HUE_W-1:0] a);
    logic [UNIT_W-1:0] r;
    if (a[HUE_W-1]) r = '0;
    else if (a > $signed({3'b000, UNIT_ONE})) r = UNIT_ONE;
    else r = a[UNIT_W-1:0];
    return r;
  endfunction

  // stage 1: offset binary plus 1792 is hue plus six turns, then drop 8 and 4 turns
  logic [16:0] u;
  logic [16:0] u_a;
  logic [14:0] h1_next;
  logic [14:0] h1;
  logic [UNIT_W-1:0] s1, v1;

  always_comb begin
    u       = {1'b0, ~hue[15], hue[14:0]} + 17'd1792;
    u_a     = (u >= 17'd46080) ? u - 17'd46080 : u;
    h1_next = (u_a >= 17'd23040) ? 15'(u_a - 17'd23040) : u_a[14:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      h1 <= h1_next;
      s1 <= clamp_unit(saturation);
      v1 <= clamp_unit(brightness);
    end
  end

  // stage 2: drop 2 and 1 turns
  logic [14:0] h_b;
  logic [12:0] h2_next;
  logic [12:0] h2;
  logic [UNIT_W-1:0] s2, v2;

  always_comb begin
    h_b     = (h1 >= 15'd11520) ? h1 - 15'd11520 : h1;
    h2_next = (h_b >= 15'd5760) ? 13'(h_b - 15'd5760) : h_b[12:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[1]) begin
      h2 <= h2_next;
      s2 <= s1;
      v2 <= v1;
    end
  end

  // stage 3: sector, distance from the sector peak, weight per channel
  logic [10:0]       f;
  logic [DIST_W-1:0] gap;
  logic [2:0]        sector;
  logic [DIST_W-1:0] dr_next, dg_next, db_next;

  always_comb begin
    if (h2 >= 13'd3840)      f = 11'(h2 - 13'd3840);
    else if (h2 >= 13'd1920) f = 11'(h2 - 13'd1920);
    else                     f = h2[10:0];
    gap = (f >= 11'd960) ? 10'(f - 11'd960) : 10'(11'd960 - f);

    priority if (h2 >= 13'd4800) sector = SEC_5;
    else if (h2 >= 13'd3840)     sector = SEC_4;
    else if (h2 >= 13'd2880)     sector = SEC_3;
    else if (h2 >= 13'd1920)     sector = SEC_2;
    else if (h2 >= 13'd960)      sector = SEC_1;
    else                         sector = SEC_0;

    // zero distance gives chroma, full distance gives nothing on top of m
    unique case (sector)
      SEC_0: begin dr_next = '0;     dg_next = gap;    db_next = D_FULL; end
      SEC_1: begin dr_next = gap;    dg_next = '0;     db_next = D_FULL; end
      SEC_2: begin dr_next = D_FULL; dg_next = '0;     db_next = gap;    end
      SEC_3: begin dr_next = D_FULL; dg_next = gap;    db_next = '0;     end
      SEC_4: begin dr_next = gap;    dg_next = D_FULL; db_next = '0;     end
      default: begin dr_next = '0;   dg_next = D_FULL; db_next = gap;    end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[2]) begin
      d_red   <= dr_next;
      d_green <= dg_next;
      d_blue  <= db_next;
      s_out   <= s2;
      v_out   <= v2;
    end
  end

endmodule

`default_nettype wire

### rtl/hsv_chan_path.sv
// hsv_chan_path: stages four to six of one color channel,
// value = (17 * v * (3932160 - s * d)) >> 30; depends on: hsv_pkg
`default_nettype none

module hsv_chan_path
  import hsv_pkg::*;
(
  input  wire logic              clk,
  input  wire hsv_ctrl_t         ctrl,
  input  wire logic [UNIT_W-1:0] s,
  input  wire logic [UNIT_W-1:0] v,
  input  wire logic [DIST_W-1:0] d,
  output logic [CH_W-1:0]        level
);

  logic [SD_W-1:0]   sd;
  logic [UNIT_W-1:0] v4;
  logic [W_W-1:0]    w;
  logic [VW_W-1:0]   vw;
  logic [VW_W+3:0]   p;

  // stage 4
  always_ff @(posedge clk) begin
    if (ctrl.en[3]) begin
      sd <= SD_W'(s) * SD_W'(d);
      v4 <= v;
    end
  end

  // stage 5, sd never exceeds the full weight
  assign w = W_FULL - sd[W_W-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.en[4]) begin
      vw <= VW_W'(v4) * VW_W'(w);
    end
  end

  // stage 6: times 17 as shift and add, top never exceeds 255
  assign p = {vw, 4'b0000} + (VW_W+4)'(vw);

  always_ff @(posedge clk) begin
    if (ctrl.en[5]) begin
      level <= p[37:30];
    end
  end

endmodule

`default_nettype wire

### rtl/hsv_to_rgb_converter.sv
// hsv_to_rgb_converter: top level, hsv pixel in, 8-bit rgb pixel out
// depends on: hsv_pkg, hsv_ifs, hsv_pipe_ctrl, hsv_hue_path, hsv_chan_path
//
// usage
//   hsv: valid-ready request channel carrying hue (1/16 degree, signed),
//        saturation and brightness (signed, 4096 = 1.0)
//   rgb: valid-ready result channel carrying red, green, blue
//   every request gives exactly one result, in order
//   throughput: one request per cycle, sustained while rgb.ready is high
//   six register stages: two for the hue wrap, one for sector and weights,
//   one per multiplier (s times distance, v times weight), one for the output
//   each stage has its own valid bit and loads when empty or moving on,
//   so bubbles are squeezed out and requests are still taken while a result
//   waits on rgb, until every stage holds one
//   receiver stall: results hold on rgb, nothing is lost or repeated
//   reset (rst, synchronous): all valid bits clear, rgb.valid goes low
`default_nettype none

module hsv_to_rgb_converter
  import hsv_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  hsv_in_if.sink     hsv,
  hsv_out_if.source  rgb
);

  hsv_ctrl_t         ctrl;
  logic [UNIT_W-1:0] s3, v3;
  logic [DIST_W-1:0] d_red, d_green, d_blue;

  hsv_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hsv.valid),
    .out_ready (rgb.ready),
    .ctrl      (ctrl)
  );

  hsv_hue_path u_hue (
    .clk        (clk),
    .ctrl       (ctrl),
    .hue        (hsv.hue),
    .saturation (hsv.saturation),
    .brightness (hsv.brightness),
    .s_out      (s3),
    .v_out      (v3),
    .d_red      (d_red),
    .d_green    (d_green),
    .d_blue     (d_blue)
  );

  hsv_chan_path u_red (
    .clk   (clk),
    .ctrl  (ctrl),
    .s     (s3),
    .v     (v3),
    .d     (d_red),
    .level (rgb.red)
  );

  hsv_chan_path u_green (
    .clk   (clk),
    .ctrl  (ctrl),
    .s     (s3),
    .v     (v3),
    .d     (d_green),
    .level (rgb.green)
  );

  hsv_chan_path u_blue (
    .clk   (clk),
    .ctrl  (ctrl),
    .s     (s3),
    .v     (v3),
    .d     (d_blue),
    .level (rgb.blue)
  );

  assign hsv.ready = ctrl.en[0];
  assign rgb.valid = ctrl.vld[STAGES-1];

endmodule

`default_nettype wire

### rtl/hsv_checker.sv
// hsv_checker: port-level checks on the converter's channels over time
// depends on: hsv_to_rgb_converter (bound to it below)
`default_nettype none

module hsv_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] red,
  input wire logic [7:0] green,
  input wire logic [7:0] blue
);

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green) && $stable(blue))
    else $error("stalled result changed");

  // a free output means every stage can take a request
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("request refused while output free");

  // with nothing taken and the output draining all along, no result appears
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && in_ready) && out_ready ##1 !(in_valid && in_ready) && out_ready
    ##1 !(in_valid && in_ready) && out_ready ##1 !(in_valid && in_ready) && out_ready
    ##1 !(in_valid && in_ready) && out_ready ##1 !(in_valid && in_ready) && out_ready
    |=> !out_valid)
    else $error("result without request");

endmodule

bind hsv_to_rgb_converter hsv_checker u_hsv_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (hsv.valid),
  .in_ready  (hsv.ready),
  .out_valid (rgb.valid),
  .out_ready (rgb.ready),
  .red       (rgb.red),
  .green     (rgb.green),
  .blue      (rgb.blue)
);

`default_nettype wire
